FILE: rtl/core/wfbp_pkg.sv
// ---------------------------------------------------------------------------
// wfbp_pkg
// Shared types and constants for the worst-fit bin packer.
// ---------------------------------------------------------------------------
package wfbp_pkg;

    localparam int MAX_PARTS = 64;
    localparam int MAX_BINS  = 16;
    localparam int PIDX_W    = 6;
    localparam int CNT_W     = 7;
    localparam int BIDX_W    = 4;
    localparam int COST_W    = 24;
    localparam int LOAD_W    = 32;

    typedef struct packed {
        logic [COST_W-1:0] part_cost;
        logic              final_part;
    } in_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0] part_index;
        logic [COST_W-1:0] placed_cost;
        logic [BIDX_W-1:0] bin_index;
        logic [LOAD_W-1:0] bin_load;
        logic              final_result;
    } out_item_t;

    // one placement handed from the sorter to the placer
    typedef struct packed {
        logic [PIDX_W-1:0] part_index;
        logic [COST_W-1:0] cost;
        logic              first;
        logic              last;
    } job_word_t;

    function automatic logic [BIDX_W:0] bins_in_use(input logic [4:0] cnt);
        logic [BIDX_W:0] b;
        if (cnt == 5'd0) begin
            b = 5'd1;
        end else if (cnt > 5'(MAX_BINS)) begin
            b = 5'(MAX_BINS);
        end else begin
            b = cnt;
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/wfbp_ram.sv
// ---------------------------------------------------------------------------
// wfbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wfbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/wfbp_front.sv
// ---------------------------------------------------------------------------
// wfbp_front
// Loads part costs, then sorts them by descending cost, one stable pass
// over the stored parts per output, and emits job words in order.
// ---------------------------------------------------------------------------
module wfbp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wfbp_pkg::in_item_t   s_item,
    input  logic                 s_valid,
    output logic                 s_ready,
    output wfbp_pkg::job_word_t  q_word,
    output logic                 q_push,
    input  logic                 q_full
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [wfbp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [wfbp_pkg::CNT_W-1:0]  done_reg, done_next;      // parts emitted
    logic [wfbp_pkg::CNT_W-1:0]  scan_reg, scan_next;      // read address in scan
    logic                        rd_vld_reg, rd_vld_next;
    logic [wfbp_pkg::PIDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [wfbp_pkg::MAX_PARTS-1:0] used_reg, used_next;
    logic                        best_vld_reg, best_vld_next;
    logic [wfbp_pkg::PIDX_W-1:0] best_idx_reg, best_idx_next;
    logic [wfbp_pkg::COST_W-1:0] best_cost_reg, best_cost_next;

    logic                        we;
    logic [wfbp_pkg::PIDX_W-1:0] raddr;
    logic [wfbp_pkg::COST_W-1:0] rdata;

    wfbp_ram #(.WIDTH(wfbp_pkg::COST_W), .DEPTH(wfbp_pkg::MAX_PARTS)) u_cost (
        .aclk  (aclk),
        .we    (we),
        .waddr (count_reg[wfbp_pkg::PIDX_W-1:0]),
        .wdata (s_item.part_cost),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_LOAD);
    assign we      = s_ready && s_valid && (count_reg < wfbp_pkg::CNT_W'(wfbp_pkg::MAX_PARTS));
    assign raddr   = scan_reg[wfbp_pkg::PIDX_W-1:0];

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        scan_next      = scan_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = raddr;
        used_next      = used_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_cost_next = best_cost_reg;
        q_push         = 1'b0;
        q_word.part_index = best_idx_reg;
        q_word.cost       = best_cost_reg;
        q_word.first      = (done_reg == '0);
        q_word.last       = (done_reg + 1'b1 == count_reg);

        // fold in the word read last cycle; strict compare keeps load order
        if (rd_vld_reg && !used_reg[rd_idx_reg]
                && (!best_vld_reg || rdata > best_cost_reg)) begin
            best_vld_next  = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_cost_next = rdata;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (we) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_item.final_part) begin
                        state_next   = ST_SCAN;
                        scan_next    = '0;
                        done_next    = '0;
                        used_next    = '0;
                        best_vld_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (count_reg == '0) begin
                    state_next = ST_LOAD;
                end else begin
                    rd_vld_next = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                    if (scan_reg + 1'b1 == count_reg) begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!q_full) begin
                    q_push        = 1'b1;
                    used_next[best_idx_reg] = 1'b1;
                    best_vld_next = 1'b0;
                    done_next     = done_reg + 1'b1;
                    scan_next     = '0;
                    if (done_reg + 1'b1 == count_reg) begin
                        state_next = ST_LOAD;
                        count_next = '0;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            done_reg     <= '0;
            scan_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            used_reg     <= '0;
            best_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            scan_reg     <= scan_next;
            rd_vld_reg   <= rd_vld_next;
            used_reg     <= used_next;
            best_vld_reg <= best_vld_next;
        end
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_cost_reg <= best_cost_next;
    end

endmodule

FILE: rtl/core/wfbp_queue.sv
// ---------------------------------------------------------------------------
// wfbp_queue
// Two-entry queue of job words between the sorter and the placer.
// ---------------------------------------------------------------------------
module wfbp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  wfbp_pkg::job_word_t push_word,
    input  logic                push,
    output logic                full,
    output wfbp_pkg::job_word_t pop_word,
    output logic                not_empty,
    input  logic                pop
);

    wfbp_pkg::job_word_t slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_word  = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            slot_reg[wptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/core/wfbp_back.sv
// ---------------------------------------------------------------------------
// wfbp_back
// Places each job word in the least-loaded bin: a serial scan over the bins
// in use, then a saturating add and a registered result.
// ---------------------------------------------------------------------------
module wfbp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [4:0]           bin_count,
    input  wfbp_pkg::job_word_t  q_word,
    input  logic                 q_valid,
    output logic                 q_pop,
    output wfbp_pkg::out_item_t  m_item,
    output logic                 m_valid,
    input  logic                 m_ready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MIN  = 3'b010,
        ST_ADD  = 3'b100
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [wfbp_pkg::LOAD_W-1:0] load_reg [wfbp_pkg::MAX_BINS];
    logic [wfbp_pkg::BIDX_W:0]   scan_reg, scan_next;
    logic [wfbp_pkg::BIDX_W-1:0] best_reg, best_next;
    logic [wfbp_pkg::BIDX_W:0]   nb;
    logic [wfbp_pkg::LOAD_W:0]   sum;
    logic [wfbp_pkg::LOAD_W-1:0] new_load;
    logic                        out_free;
    logic                        clear;
    wfbp_pkg::out_item_t         out_reg;
    logic                        out_vld_reg;

    assign nb       = wfbp_pkg::bins_in_use(bin_count);
    assign out_free = !out_vld_reg || m_ready;
    assign sum      = {1'b0, load_reg[best_reg]} + (wfbp_pkg::LOAD_W+1)'(q_word.cost);
    assign new_load = sum[wfbp_pkg::LOAD_W] ? '1 : sum[wfbp_pkg::LOAD_W-1:0];
    assign m_item   = out_reg;
    assign m_valid  = out_vld_reg;
    // loads of a new job count as zero until written
    assign clear    = q_word.first;

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        best_next  = best_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_MIN;
                    scan_next  = 5'd1;
                    best_next  = '0;
                end
            end
            ST_MIN: begin
                if (scan_reg >= nb || clear) begin
                    state_next = ST_ADD;
                end else begin
                    if (load_reg[scan_reg[wfbp_pkg::BIDX_W-1:0]] < load_reg[best_reg]) begin
                        best_next = scan_reg[wfbp_pkg::BIDX_W-1:0];
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
        scan_reg <= scan_next;
        best_reg <= best_next;
        if (q_pop) begin
            for (int i = 0; i < wfbp_pkg::MAX_BINS; i++) begin
                if (clear) begin
                    load_reg[i] <= '0;
                end
            end
            if (clear) begin
                load_reg[0] <= (wfbp_pkg::LOAD_W)'(q_word.cost);
            end else begin
                load_reg[best_reg] <= new_load;
            end
            out_reg.part_index   <= q_word.part_index;
            out_reg.placed_cost  <= q_word.cost;
            out_reg.bin_index    <= clear ? '0 : best_reg;
            out_reg.bin_load     <= clear ? (wfbp_pkg::LOAD_W)'(q_word.cost) : new_load;
            out_reg.final_result <= q_word.last;
        end
    end

endmodule

FILE: rtl/core/worst_fit_bin_packer.sv
// ---------------------------------------------------------------------------
// worst_fit_bin_packer
// Longest-cost-first, worst-fit placement of up to 64 parts into bins.
// ---------------------------------------------------------------------------
// Usage: parts arrive on s_ (valid/ready), one cost per word; final_part
// closes the job. Loading accepts one part per cycle; parts beyond 64 are
// dropped. After the final part the front end sorts: for each output it
// scans the stored costs once through the cost RAM. Each placement word
// then passes a two-entry queue to the back end, which scans the bins in
// use (up to 16) and adds with saturation, skipping the scan for the first
// part of a job; results leave on m_ one per part in sorted order, the
// last flagged final_result. s_ready stays low until the whole job has
// been handed to the queue.
// A stall on m_ holds the output register, then fills the queue, then
// halts the sorter; nothing is lost. Reset clears all control state and
// returns bin_count to 4; write bin_count only while the block is idle.
// ---------------------------------------------------------------------------
module worst_fit_bin_packer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_wdata,
    input  wfbp_pkg::in_item_t  s_item,
    input  logic                s_valid,
    output logic                s_ready,
    output wfbp_pkg::out_item_t m_item,
    output logic                m_valid,
    input  logic                m_ready
);

    logic [4:0]          bin_count_reg;
    wfbp_pkg::job_word_t f_word, b_word;
    logic                f_push, q_full, q_ne, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= 5'd4;
        end else if (cfg_we) begin
            bin_count_reg <= cfg_wdata;
        end
    end

    wfbp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_word  (f_word),
        .q_push  (f_push),
        .q_full  (q_full)
    );

    wfbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_word (f_word),
        .push      (f_push),
        .full      (q_full),
        .pop_word  (b_word),
        .not_empty (q_ne),
        .pop       (q_pop)
    );

    wfbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bin_count (bin_count_reg),
        .q_word    (b_word),
        .q_valid   (q_ne),
        .q_pop     (q_pop),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(f_push && q_full && !q_pop)) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_ne) else $error("pop from empty queue");
    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_item.bin_index} < wfbp_pkg::bins_in_use(bin_count_reg)))
        else $error("bin index out of range");
`endif

endmodule
